[sv/step_sequenced_gain_gate_top_defines.svh]
// Assertion macros shared by the gain gate RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef STEP_SEQUENCED_GAIN_GATE_TOP_DEFINES_SVH
`define STEP_SEQUENCED_GAIN_GATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SSGG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SSGG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ssgg_pkg.sv]
// Shared types, constants and helpers for the step-sequenced gain gate.
// No dependencies; imported by every module of the block.
package ssgg_pkg;

  localparam int LVL_W     = 16;
  localparam int FRAC_W    = 15;
  localparam int STEP_W    = 4;
  localparam int STEPS_W   = 5;
  localparam int OUT_BITS  = 24;
  localparam int DIVD_W    = 31;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = 16;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;
  localparam int INC_REG_W = 32;
  localparam int NUM_LVL_WORDS = 4;

  localparam logic [16:0] ONE_Q15   = 17'd32768;
  localparam logic [15:0] RAMP_MIN  = 16'd328;
  localparam logic [4:0]  MAX_SLOTS = 5'd16;

  localparam logic [31:0] RST_PHASE_INC = 32'd178957;
  localparam logic [4:0]  RST_STEPS     = 5'd16;
  localparam logic [15:0] RST_RAMP      = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_0_3   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_4_7   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_8_11  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_12_15 = 4'd7;

  // Clamped configuration seen by the front and back halves.
  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic [LVL_W-1:0]   atk;
    logic [LVL_W-1:0]   rel;
  } cfg_t;

  // One classified item waiting for the back half.
  typedef struct packed {
    logic              halted;
    logic [FRAC_W-1:0] frac;
    logic [STEP_W-1:0] act_idx;
    logic [STEP_W-1:0] prv_idx;
    logic [STEP_W-1:0] nxt_idx;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic [3:0] {
    B_IDLE,
    B_LACT,
    B_LPRV,
    B_LNXT,
    B_MUL,
    B_ASTART,
    B_AWAIT,
    B_RSTART,
    B_RWAIT,
    B_GAIN,
    B_SCALE
  } back_state_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = v;
    if ({1'b0, v} > ONE_Q15) r = ONE_Q15[LVL_W-1:0];
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_ramp(input logic [LVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = v;
    if (v < RAMP_MIN) r = RAMP_MIN;
    if ({1'b0, v} > ONE_Q15) r = ONE_Q15[LVL_W-1:0];
    return r;
  endfunction

endpackage

[sv/ssgg_regs.sv]
// Configuration register file: write decode, reset values, clamping and
// the level lookup port. Depends on ssgg_pkg.
module ssgg_regs #(
  parameter int PHASE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssgg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssgg_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic [PHASE_BITS-1:0]            phase_inc,
  output ssgg_pkg::cfg_t                   cfg,
  input  logic [ssgg_pkg::STEP_W-1:0]      lvl_addr,
  output logic [ssgg_pkg::LVL_W-1:0]       lvl_data
);
  import ssgg_pkg::*;

  localparam int IW = (PHASE_BITS > INC_REG_W) ? PHASE_BITS : INC_REG_W;

  logic [INC_REG_W-1:0] inc_r;
  logic [STEPS_W-1:0]   steps_r;
  logic [LVL_W-1:0]     atk_r;
  logic [LVL_W-1:0]     rel_r;
  logic [CFG_DAT_W-1:0] lvl_r [NUM_LVL_WORDS];

  logic [IW-1:0]        inc_w;
  logic [CFG_DAT_W-1:0] lvl_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= RST_PHASE_INC;
      steps_r <= RST_STEPS;
      atk_r   <= RST_RAMP;
      rel_r   <= RST_RAMP;
      for (int i = 0; i < NUM_LVL_WORDS; i++) lvl_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INC: inc_r    <= cfg_data[INC_REG_W-1:0];
        REG_STEPS:     steps_r  <= cfg_data[STEPS_W-1:0];
        REG_ATTACK:    atk_r    <= cfg_data[LVL_W-1:0];
        REG_RELEASE:   rel_r    <= cfg_data[LVL_W-1:0];
        REG_LVL_0_3:   lvl_r[0] <= cfg_data;
        REG_LVL_4_7:   lvl_r[1] <= cfg_data;
        REG_LVL_8_11:  lvl_r[2] <= cfg_data;
        REG_LVL_12_15: lvl_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mask or extend the increment to the phase width.
  assign inc_w     = IW'(inc_r);
  assign phase_inc = inc_w[PHASE_BITS-1:0];

  always_comb begin
    cfg.steps = steps_r;
    if (steps_r == '0) cfg.steps = STEPS_W'(1);
    if (steps_r > MAX_SLOTS) cfg.steps = MAX_SLOTS;
    cfg.atk = clamp_ramp(atk_r);
    cfg.rel = clamp_ramp(rel_r);
  end

  assign lvl_word = lvl_r[lvl_addr[STEP_W-1:2]];
  assign lvl_data = clamp_level(lvl_word[lvl_addr[1:0]*LVL_W +: LVL_W]);

endmodule

[sv/ssgg_front.sv]
// Front half: accepts items, runs the phase accumulator and step tracking,
// and pushes one classified job per item into the queue. Depends on ssgg_pkg.
module ssgg_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  load_position,
  input  logic [PHASE_BITS-1:0] new_position,
  input  logic [PHASE_BITS-1:0] phase_inc,
  input  ssgg_pkg::cfg_t        cfg,
  input  logic                  q_full,
  output logic                  push,
  output ssgg_pkg::job_t        job
);
  import ssgg_pkg::*;

  localparam int PW = PHASE_BITS + STEPS_W;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]     act_r, act_nxt;
  logic [STEP_W-1:0]     prv_r, prv_nxt;
  logic                  seen_r, seen_nxt;

  logic [PHASE_BITS-1:0] ph;
  logic [PW-1:0]         prod;
  logic [STEP_W-1:0]     idx;
  logic [STEPS_W-1:0]    idx_inc;
  logic                  run;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign ph      = load_position ? new_position : phase_r;
  assign run     = (phase_inc != '0);
  assign prod    = PW'(ph) * PW'(cfg.steps);
  assign idx     = prod[PHASE_BITS +: STEP_W];
  assign idx_inc = {1'b0, idx} + STEPS_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    prv_nxt   = prv_r;
    seen_nxt  = seen_r;
    if (push) begin
      phase_nxt = ph + phase_inc;
      if (run) begin
        if (!seen_r) begin
          act_nxt  = idx;
          prv_nxt  = idx;
          seen_nxt = 1'b1;
        end else if (act_r != idx) begin
          prv_nxt = act_r;
          act_nxt = idx;
        end
      end
    end
  end

  always_comb begin
    job.halted  = !run;
    job.frac    = prod[PHASE_BITS-1 -: FRAC_W];
    job.act_idx = idx;
    job.prv_idx = prv_nxt;
    job.nxt_idx = (idx_inc < cfg.steps) ? idx_inc[STEP_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      act_r   <= '0;
      prv_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      prv_r   <= prv_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[sv/ssgg_fifo.sv]
// Short job queue between the front and back halves.
// Depends on ssgg_pkg for its depth.
module ssgg_fifo #(
  parameter int DW = 76
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  import ssgg_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [DW-1:0] mem_r [QDEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == AW'(QDEPTH - 1)) ? '0 : wptr_r + AW'(1);
      if (do_pop)  rptr_r <= (rptr_r == AW'(QDEPTH - 1)) ? '0 : rptr_r + AW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/ssgg_div.sv]
// Restoring divider, one quotient bit per cycle, for the ramp slopes.
// Quotient is known to stay below 2^16. Depends on ssgg_pkg.
module ssgg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssgg_pkg::DIVD_W-1:0] dividend,
  input  logic [ssgg_pkg::LVL_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [ssgg_pkg::QUO_W-1:0]  quotient
);
  import ssgg_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W = DIVD_W - QUO_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] lo_r, lo_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [LVL_W-1:0] d_r, d_nxt;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign ge    = (trial >= d_r);
  assign diff  = trial - d_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[DIVD_W-1 -: REM_W];
      lo_nxt   = dividend[QUO_W-1:0];
      d_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      lo_nxt  = {lo_r[QUO_W-2:0], 1'b0};
      q_nxt   = {q_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

[sv/ssgg_back.sv]
// Back half: looks up step levels, builds the ramped gain with the shared
// divider, scales both samples and holds the result. Depends on ssgg_pkg,
// ssgg_div and the assertion macros.
`include "step_sequenced_gain_gate_top_defines.svh"

module ssgg_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        q_empty,
  output logic                                        q_pop,
  input  logic [ssgg_pkg::JOB_W+2*SAMPLE_BITS-1:0]    q_data,
  input  ssgg_pkg::cfg_t                              cfg,
  output logic [ssgg_pkg::STEP_W-1:0]                 lvl_addr,
  input  logic [ssgg_pkg::LVL_W-1:0]                  lvl_data,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ssgg_pkg::OUT_BITS-1:0]               out_left,
  output logic [ssgg_pkg::OUT_BITS-1:0]               out_right,
  output logic [ssgg_pkg::LVL_W-1:0]                  out_gain
);
  import ssgg_pkg::*;

  localparam int PRD_W = SAMPLE_BITS + LVL_W + 1;
  localparam int EXT_W = (PRD_W > OUT_BITS) ? PRD_W : OUT_BITS;

  back_state_t state_r, state_nxt;

  job_t                   job_r;
  logic [SAMPLE_BITS-1:0] sl_r, sr_r;
  logic [LVL_W-1:0]       act_r, prv_r, nxt_r;
  logic                   atk_on_r, rel_on_r;
  logic [DIVD_W-1:0]      da_r, dr_r;
  logic [QUO_W-1:0]       qa_r, qr_r;
  logic [LVL_W-1:0]       gain_r;
  logic                   out_valid_r;
  logic [OUT_BITS-1:0]    out_l_r, out_r_r;
  logic [LVL_W-1:0]       out_g_r;

  logic                   div_start, div_busy, div_done;
  logic [DIVD_W-1:0]      div_dividend;
  logic [LVL_W-1:0]       div_divisor;
  logic [QUO_W-1:0]       div_q;
  logic                   out_load;

  logic [16:0]            frac_x, rel_thr, rel_dist;
  logic [LVL_W-1:0]       up_span, dn_span;
  logic signed [17:0]     g_att, g_rel;
  logic signed [PRD_W-1:0] prd_l, prd_r, sh_l, sh_r;
  logic signed [EXT_W-1:0] ext_l, ext_r;

  ssgg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = da_r;
    div_divisor  = cfg.atk;
    out_load     = 1'b0;
    case (state_r)
      B_LACT:  lvl_addr = job_r.act_idx;
      B_LPRV:  lvl_addr = job_r.prv_idx;
      default: lvl_addr = job_r.nxt_idx;
    endcase
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_LACT;
        end
      end
      B_LACT: state_nxt = B_LPRV;
      B_LPRV: state_nxt = B_LNXT;
      B_LNXT: state_nxt = B_MUL;
      B_MUL:  state_nxt = B_ASTART;
      B_ASTART: begin
        div_start = atk_on_r;
        state_nxt = atk_on_r ? B_AWAIT : B_RSTART;
      end
      B_AWAIT: begin
        if (div_done) state_nxt = B_RSTART;
      end
      B_RSTART: begin
        div_start    = rel_on_r;
        div_dividend = dr_r;
        div_divisor  = cfg.rel;
        state_nxt    = rel_on_r ? B_RWAIT : B_GAIN;
      end
      B_RWAIT: begin
        if (div_done) state_nxt = B_GAIN;
      end
      B_GAIN: state_nxt = B_SCALE;
      B_SCALE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Ramp operands.
  assign frac_x   = {2'b00, act_r == '0 ? job_r.frac : job_r.frac};
  assign rel_thr  = ONE_Q15 - {1'b0, cfg.rel};
  assign rel_dist = frac_x - rel_thr;
  assign up_span  = act_r - prv_r;
  assign dn_span  = act_r - nxt_r;

  assign g_att = atk_on_r ? $signed({2'b00, prv_r}) + $signed({2'b00, qa_r})
                          : $signed({2'b00, act_r});
  assign g_rel = rel_on_r ? g_att - $signed({2'b00, qr_r}) : g_att;

  assign prd_l = $signed(sl_r) * $signed({1'b0, gain_r});
  assign prd_r = $signed(sr_r) * $signed({1'b0, gain_r});
  assign sh_l  = prd_l >>> FRAC_W;
  assign sh_r  = prd_r >>> FRAC_W;
  assign ext_l = EXT_W'(sh_l);
  assign ext_r = EXT_W'(sh_r);

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          job_r <= job_t'(q_data[JOB_W-1:0]);
          sl_r  <= q_data[JOB_W +: SAMPLE_BITS];
          sr_r  <= q_data[JOB_W+SAMPLE_BITS +: SAMPLE_BITS];
        end
      end
      // A halted sequence forces the active level, and with it the gain, to zero.
      B_LACT: act_r <= job_r.halted ? '0 : lvl_data;
      B_LPRV: prv_r <= lvl_data;
      B_LNXT: nxt_r <= lvl_data;
      B_MUL: begin
        atk_on_r <= ({1'b0, job_r.frac} < cfg.atk) && (prv_r < act_r);
        rel_on_r <= (frac_x > rel_thr) && (nxt_r < act_r);
        da_r     <= DIVD_W'(job_r.frac) * DIVD_W'(up_span);
        dr_r     <= DIVD_W'(rel_dist[FRAC_W-1:0]) * DIVD_W'(dn_span);
      end
      B_AWAIT: if (div_done) qa_r <= div_q;
      B_RWAIT: if (div_done) qr_r <= div_q;
      B_GAIN: begin
        if (g_rel < 0) gain_r <= '0;
        else if (g_rel > $signed({1'b0, ONE_Q15})) gain_r <= ONE_Q15[LVL_W-1:0];
        else gain_r <= g_rel[LVL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r <= ext_l[OUT_BITS-1:0];
      out_r_r <= ext_r[OUT_BITS-1:0];
      out_g_r <= gain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (out_load)   out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;
  assign out_gain  = out_g_r;

  `SSGG_ASSERT_IMPL(a_div_start_idle, div_start, !div_busy, "divider started while busy")
  `SSGG_ASSERT_IMPL(a_div_done_wait, div_done, (state_r == B_AWAIT) || (state_r == B_RWAIT), "divider result with nobody waiting")
  `SSGG_ASSERT_NEXT(a_out_load, out_load, out_valid_r, "loaded result not presented")
  `SSGG_ASSERT_IMPL(a_gain_range, out_valid_r, {1'b0, out_g_r} <= ONE_Q15, "gain above unity")

endmodule

[sv/step_sequenced_gain_gate_top.sv]
// Top level of the step-sequenced stereo gain gate.
// Depends on ssgg_pkg, ssgg_regs, ssgg_front, ssgg_fifo and ssgg_back.
//
// Usage:
//   in_*  : one stereo pair per transfer. tdata = {new_position, sample_right,
//           sample_left}, tuser[0] = load_position (loads the phase first).
//   out_* : one result per input. tdata = {gain_used, out_right, out_left}.
//   cfg_* : register writes, always ready; write only while the block is idle.
// The front accepts an item and queues it (two entries). The back works on
// one item at a time: it looks up three step levels, runs the 16-step
// shared divider that computes the ramp slopes once per active ramp, then
// builds the gain and scales both samples.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// phase and step tracking and empties the queue and output register.
// When the receiver stalls, the result waits in the output register, the
// back finishes at most one more item, and in_tready drops once the queue
// is full; nothing is lost or repeated.
module step_sequenced_gain_gate_top #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // sample_left, sample_right, new_position, zero fill
  input  logic [((2*SAMPLE_BITS+PHASE_BITS+7)/8)*8-1:0] in_tdata,
  // load_position
  input  logic [0:0]                                    in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_left, out_right, gain_used
  output logic [63:0]                                   out_tdata,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [ssgg_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [ssgg_pkg::CFG_DAT_W-1:0]                cfg_data
);
  import ssgg_pkg::*;

  localparam int QW = JOB_W + 2*SAMPLE_BITS;

  logic [PHASE_BITS-1:0] phase_inc;
  cfg_t                  cfg;
  logic [STEP_W-1:0]     lvl_addr;
  logic [LVL_W-1:0]      lvl_data;
  logic                  q_push, q_full, q_pop, q_empty;
  job_t                  job;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic [OUT_BITS-1:0]   res_left, res_right;
  logic [LVL_W-1:0]      res_gain;

  ssgg_regs #(.PHASE_BITS(PHASE_BITS)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .phase_inc (phase_inc),
    .cfg       (cfg),
    .lvl_addr  (lvl_addr),
    .lvl_data  (lvl_data)
  );

  ssgg_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .load_position (in_tuser[0]),
    .new_position  (in_tdata[2*SAMPLE_BITS +: PHASE_BITS]),
    .phase_inc     (phase_inc),
    .cfg           (cfg),
    .q_full        (q_full),
    .push          (q_push),
    .job           (job)
  );

  assign q_wdata = {in_tdata[2*SAMPLE_BITS-1:0], job};

  ssgg_fifo #(.DW(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  ssgg_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .cfg       (cfg),
    .lvl_addr  (lvl_addr),
    .lvl_data  (lvl_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (res_left),
    .out_right (res_right),
    .out_gain  (res_gain)
  );

  assign out_tdata = {res_gain, res_right, res_left};

endmodule
